### design/pwrm_pkg.sv
package pwrm_pkg;

    // ring of per-second pulse counts
    localparam int WINDOW  = 8;
    localparam int SLOT_W  = (WINDOW > 2) ? $clog2(WINDOW) : 1;
    localparam int CNT_DW  = 16;
    // sum of WINDOW-1 slots
    localparam int SUM_W   = CNT_DW + $clog2(WINDOW);
    // remainder up to WINDOW
    localparam int DIV_W   = $clog2(WINDOW + 1);

    // reciprocal constants, exact for every dividend below 2**SUM_W
    localparam int MUL_W   = SUM_W + 1;
    localparam int PROD_W  = SUM_W + MUL_W;
    localparam int RING_SH = SUM_W + $clog2(WINDOW);
    localparam int RATE_SH = SUM_W + $clog2(WINDOW - 1);
    localparam logic [MUL_W-1:0] RING_MUL =
        MUL_W'((64'd1 << RING_SH) / 64'(WINDOW) + 64'd1);
    localparam logic [MUL_W-1:0] RATE_MUL =
        MUL_W'((64'd1 << RATE_SH) / 64'(WINDOW - 1) + 64'd1);

    localparam logic [CNT_DW-1:0] CNT_MAX    = '1;
    localparam logic [SLOT_W-1:0] RESET_SLOT = SLOT_W'(32'hFFFF % WINDOW);
    localparam logic [DIV_W-1:0]  RING_DIV   = DIV_W'(WINDOW);
    localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(WINDOW - 1);

    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 48;

    typedef enum logic {
        FUNC_TICK = 1'b0,
        FUNC_EDGE = 1'b1
    } func_t;

    typedef enum logic {
        DIV_RING = 1'b0,
        DIV_RATE = 1'b1
    } div_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD_GO,
        ST_MOD_WAIT,
        ST_CLR,
        ST_SUM,
        ST_SUM_END,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_INC_RD,
        ST_INC_WR,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic             start;
        div_sel_t         sel;
        logic [SUM_W-1:0] dividend;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
        logic [DIV_W-1:0] remainder;
    } div_rsp_t;

endpackage

### design/pwrm_div.sv
// Division by WINDOW or WINDOW-1 through reciprocal multiplication.
// Product registered in the cycle after start, quotient and remainder registered from it after that.
// The remainder is only meaningful for division by WINDOW.
module pwrm_div (
    input  logic              clk,
    input  logic              rst_n,
    input  pwrm_pkg::div_req_t req,
    output pwrm_pkg::div_rsp_t rsp
);

    logic [pwrm_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic [pwrm_pkg::SUM_W-1:0]  x_reg,    x_next;
    pwrm_pkg::div_sel_t          sel_reg,  sel_next;
    logic [pwrm_pkg::SUM_W-1:0]  quo_reg,  quo_next;
    logic [pwrm_pkg::DIV_W-1:0]  rem_reg,  rem_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [pwrm_pkg::MUL_W-1:0]  mul_k;
    logic [pwrm_pkg::SUM_W-1:0]  quo_w;
    logic [pwrm_pkg::DIV_W-1:0]  rem_w;

    assign mul_k = (req.sel == pwrm_pkg::DIV_RING) ? pwrm_pkg::RING_MUL : pwrm_pkg::RATE_MUL;
    assign quo_w = (sel_reg == pwrm_pkg::DIV_RING)
                 ? pwrm_pkg::SUM_W'(prod_reg >> pwrm_pkg::RING_SH)
                 : pwrm_pkg::SUM_W'(prod_reg >> pwrm_pkg::RATE_SH);
    // remainder is below WINDOW, so the low bits alone give it exactly
    assign rem_w = x_reg[pwrm_pkg::DIV_W-1:0]
                 - pwrm_pkg::DIV_W'(quo_w[pwrm_pkg::DIV_W-1:0] * pwrm_pkg::RING_DIV);

    always_comb
    begin
        prod_next = prod_reg;
        x_next    = x_reg;
        sel_next  = sel_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        busy_next = 1'b0;
        done_next = 1'b0;
        if (req.start)
        begin
            x_next    = req.dividend;
            sel_next  = req.sel;
            prod_next = pwrm_pkg::PROD_W'(req.dividend) * pwrm_pkg::PROD_W'(mul_k);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next  = quo_w;
            rem_next  = rem_w;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        x_reg    <= x_next;
        sel_reg  <= sel_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

### design/pulse_width_and_rate_meter_unit.sv
// Channel  Dir  Bits  Contents (lowest bit first)
// s        in   24    tdata: pin_level[0], seconds[16:1], zero pad; tuser: func
// m        out  48    tdata: current_length, last_length, pulse_rate
//
// One item at a time; s_tready is high only while the sequencer idles.
// Tick, rising edge: straight to the result. Falling edge, same second: the current
// slot is read and incremented first. Falling edge, new second: slot index by one
// reciprocal-multiply division, slot clear, slot-by-slot sum, rate by a second division, then the increment.
// Reset does not clear the slot memory or the sum registers; slot valid bits stand in for a zeroed ring.
// A result held by m_tready stalls the block until it is taken.
module pulse_width_and_rate_meter_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [pwrm_pkg::S_DATA_W-1:0] s_tdata,   // pin_level, seconds, pad
    input  logic [0:0]                    s_tuser,   // func
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [pwrm_pkg::M_DATA_W-1:0] m_tdata    // current_length, last_length, pulse_rate
);

    pwrm_pkg::state_t state_reg, state_next;

    logic [pwrm_pkg::CNT_DW-1:0] len_reg,    len_next;
    logic [pwrm_pkg::CNT_DW-1:0] last_reg,   last_next;
    logic [pwrm_pkg::CNT_DW-1:0] seen_reg,   seen_next;
    logic [pwrm_pkg::CNT_DW-1:0] rate_reg,   rate_next;
    logic [pwrm_pkg::SLOT_W-1:0] slot_reg,   slot_next;
    logic [pwrm_pkg::SLOT_W-1:0] idx_reg,    idx_next;
    logic [pwrm_pkg::SUM_W-1:0]  sum_reg,    sum_next;
    logic                        acc_vld_reg, acc_vld_next;
    logic [pwrm_pkg::WINDOW-1:0] slot_vld_reg;

    logic [pwrm_pkg::CNT_DW-1:0] slot_mem [pwrm_pkg::WINDOW];
    logic [pwrm_pkg::CNT_DW-1:0] rd_raw_reg;
    logic                        rd_vld_reg;
    logic [pwrm_pkg::CNT_DW-1:0] rd_val;

    logic                        mem_we;
    logic [pwrm_pkg::SLOT_W-1:0] mem_waddr;
    logic [pwrm_pkg::SLOT_W-1:0] mem_raddr;
    logic [pwrm_pkg::CNT_DW-1:0] mem_wdata;

    pwrm_pkg::div_req_t div_req;
    pwrm_pkg::div_rsp_t div_rsp;

    logic                        in_xfer;
    pwrm_pkg::func_t             in_func;
    logic                        in_pin;
    logic [pwrm_pkg::CNT_DW-1:0] in_sec;

    assign in_func = pwrm_pkg::func_t'(s_tuser[0]);
    assign in_pin  = s_tdata[0];
    assign in_sec  = s_tdata[16:1];
    assign in_xfer = s_tvalid && s_tready;
    assign rd_val  = rd_vld_reg ? rd_raw_reg : '0;

    pwrm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pwrm_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (in_func == pwrm_pkg::FUNC_EDGE && !in_pin)
                        state_next = (in_sec != seen_reg) ? pwrm_pkg::ST_MOD_GO
                                                          : pwrm_pkg::ST_INC_RD;
                    else
                        state_next = pwrm_pkg::ST_OUT;
                end
            end
            pwrm_pkg::ST_MOD_GO:   state_next = pwrm_pkg::ST_MOD_WAIT;
            pwrm_pkg::ST_MOD_WAIT: if (div_rsp.done) state_next = pwrm_pkg::ST_CLR;
            pwrm_pkg::ST_CLR:      state_next = pwrm_pkg::ST_SUM;
            pwrm_pkg::ST_SUM:
                if (idx_reg == pwrm_pkg::LAST_SLOT) state_next = pwrm_pkg::ST_SUM_END;
            pwrm_pkg::ST_SUM_END:  state_next = pwrm_pkg::ST_DIV_GO;
            pwrm_pkg::ST_DIV_GO:   state_next = pwrm_pkg::ST_DIV_WAIT;
            pwrm_pkg::ST_DIV_WAIT: if (div_rsp.done) state_next = pwrm_pkg::ST_INC_RD;
            pwrm_pkg::ST_INC_RD:   state_next = pwrm_pkg::ST_INC_WR;
            pwrm_pkg::ST_INC_WR:   state_next = pwrm_pkg::ST_OUT;
            pwrm_pkg::ST_OUT:      if (m_tready) state_next = pwrm_pkg::ST_IDLE;
            default:               state_next = pwrm_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        s_tready         = 1'b0;
        m_tvalid         = 1'b0;
        mem_we           = 1'b0;
        mem_waddr        = slot_reg;
        mem_wdata        = '0;
        mem_raddr        = slot_reg;
        div_req.start    = 1'b0;
        div_req.sel      = pwrm_pkg::DIV_RING;
        div_req.dividend = pwrm_pkg::SUM_W'(seen_reg);
        case (state_reg)
            pwrm_pkg::ST_IDLE:   s_tready = 1'b1;
            pwrm_pkg::ST_MOD_GO: div_req.start = 1'b1;
            pwrm_pkg::ST_CLR:    mem_we = 1'b1;
            pwrm_pkg::ST_SUM:    mem_raddr = idx_reg;
            pwrm_pkg::ST_DIV_GO:
            begin
                div_req.start    = 1'b1;
                div_req.sel      = pwrm_pkg::DIV_RATE;
                div_req.dividend = sum_reg;
            end
            pwrm_pkg::ST_INC_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = (rd_val != pwrm_pkg::CNT_MAX) ? rd_val + 1'b1 : rd_val;
            end
            pwrm_pkg::ST_OUT:    m_tvalid = 1'b1;
            default:             ;
        endcase
    end

    // datapath
    always_comb
    begin
        len_next     = len_reg;
        last_next    = last_reg;
        seen_next    = seen_reg;
        rate_next    = rate_reg;
        slot_next    = slot_reg;
        idx_next     = idx_reg;
        sum_next     = sum_reg;
        acc_vld_next = (state_reg == pwrm_pkg::ST_SUM);
        if (acc_vld_reg)
            sum_next = sum_reg + pwrm_pkg::SUM_W'(rd_val);
        case (state_reg)
            pwrm_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (in_func == pwrm_pkg::FUNC_TICK)
                    begin
                        if (in_pin && len_reg != pwrm_pkg::CNT_MAX)
                            len_next = len_reg + 1'b1;
                    end
                    else if (!in_pin)
                    begin
                        last_next = len_reg;
                        len_next  = '0;
                        seen_next = in_sec;
                    end
                end
            end
            pwrm_pkg::ST_MOD_WAIT:
                if (div_rsp.done) slot_next = div_rsp.remainder[pwrm_pkg::SLOT_W-1:0];
            pwrm_pkg::ST_CLR:
            begin
                // the cleared slot is read back as zero, so the sum covers all slots
                idx_next = '0;
                sum_next = '0;
            end
            pwrm_pkg::ST_SUM:      idx_next = idx_reg + 1'b1;
            pwrm_pkg::ST_DIV_WAIT:
                if (div_rsp.done) rate_next = div_rsp.quotient[pwrm_pkg::CNT_DW-1:0];
            default:               ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= pwrm_pkg::ST_IDLE;
            len_reg      <= '0;
            last_reg     <= '0;
            seen_reg     <= pwrm_pkg::CNT_MAX;
            rate_reg     <= '0;
            slot_reg     <= pwrm_pkg::RESET_SLOT;
            acc_vld_reg  <= 1'b0;
            slot_vld_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            last_reg    <= last_next;
            seen_reg    <= seen_next;
            rate_reg    <= rate_next;
            slot_reg    <= slot_next;
            acc_vld_reg <= acc_vld_next;
            if (mem_we)
                slot_vld_reg[mem_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        sum_reg <= sum_next;
    end

    // slot count memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            slot_mem[mem_waddr] <= mem_wdata;
        rd_raw_reg <= slot_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_vld_reg <= 1'b0;
        else
            rd_vld_reg <= slot_vld_reg[mem_raddr];
    end

    assign m_tdata = {rate_reg, last_reg, len_reg};

endmodule
